// ===== hw/rtl/rled_pkg.sv =====
package rled_pkg;

  // Special byte codes of the encoded stream
  localparam logic [7:0] ESCAPE_BYTE = 8'h55;
  localparam int unsigned MARK_BIT = 7;

  // Frame status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_OVERRUN = 2'd1;
  localparam logic [1:0] STATUS_TRUNC   = 2'd2;

  localparam logic [15:0] LENGTH_RESET = 16'd8192;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  byte_first;
    logic [7:0]  byte_second;
    logic [1:0]  bytes_valid;
    logic        run_end;
    logic        frame_done;
    logic [1:0]  status;
    logic [15:0] produced_count;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // take the input word
    logic step;   // emit one word of the current run
  } rled_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;  // output register empty or being drained
    logic run_start;  // the loaded word starts a run
    logic run_final;  // the current run ends with this step
  } rled_stat_t;

endpackage

// ===== hw/rtl/rled_ctrl.sv =====
module rled_ctrl
  import rled_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  rled_stat_t stat,
  output rled_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Handshake and commands
  always_comb begin
    in_ready = (state == ST_IDLE) && stat.slot_free;
    cmd.load = in_valid && in_ready;
    cmd.step = (state == ST_RUN) && stat.slot_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load && stat.run_start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.step && stat.run_final) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/rled_datapath.sv =====
module rled_datapath
  import rled_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  in_word_t    in_data,
  input  rled_cmd_t   cmd,
  output rled_stat_t  stat,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data
);

  // Frame state
  logic [15:0] expected_length;
  logic        awaiting;
  logic        awaiting_next;
  logic [6:0]  pending;
  logic [6:0]  pending_next;
  logic [15:0] total;
  logic [15:0] total_next;
  logic        halted;
  logic        halted_next;

  // Run being emitted
  logic [6:0]  remain;
  logic [6:0]  remain_next;
  logic [7:0]  run_byte;
  logic        run_last;

  // Decode signals
  logic        is_code;
  logic [6:0]  code_cnt;
  logic [6:0]  run_len;
  logic        over_code;
  logic        over_pend;
  logic        emit_empty;
  logic [1:0]  empty_status;
  logic        start_run;
  logic [1:0]  nv;
  logic [15:0] total_step;
  logic        step_final;
  logic        step_done;

  always_comb begin
    is_code   = (in_data.in_byte == ESCAPE_BYTE) || in_data.in_byte[MARK_BIT];
    code_cnt  = (in_data.in_byte == ESCAPE_BYTE) ? 7'd1 : in_data.in_byte[6:0];
    run_len   = awaiting ? pending : 7'd1;
    over_code = ({1'b0, total} + {10'd0, code_cnt}) > {1'b0, expected_length};
    over_pend = ({1'b0, total} + {10'd0, pending}) > {1'b0, expected_length};
    nv         = (remain >= 7'd2) ? 2'd2 : 2'd1;
    total_step = total + {14'd0, nv};
    step_final = (remain == {5'd0, nv});
    step_done  = step_final && (run_last || (total_step == expected_length));
  end

  // Per-word decision, run stepping and frame state update
  always_comb begin
    awaiting_next = awaiting;
    pending_next  = pending;
    total_next    = total;
    halted_next   = halted;
    remain_next   = remain;
    emit_empty    = 1'b0;
    empty_status  = STATUS_OK;
    start_run     = 1'b0;
    if (cmd.load) begin
      if (halted) begin
        if (in_data.in_last) begin
          halted_next = 1'b0;
          total_next  = '0;
        end
      end else if (total >= expected_length) begin
        emit_empty   = 1'b1;
        empty_status = STATUS_OK;
      end else if (!awaiting && is_code) begin
        if (over_code) begin
          emit_empty   = 1'b1;
          empty_status = STATUS_OVERRUN;
        end else if (in_data.in_last) begin
          emit_empty   = 1'b1;
          empty_status = STATUS_TRUNC;
        end else begin
          awaiting_next = 1'b1;
          pending_next  = code_cnt;
        end
      end else begin
        awaiting_next = 1'b0;
        pending_next  = '0;
        if (awaiting && over_pend) begin
          emit_empty   = 1'b1;
          empty_status = STATUS_OVERRUN;
        end else if (run_len == 7'd0) begin
          emit_empty   = in_data.in_last;
          empty_status = STATUS_OK;
        end else begin
          start_run   = 1'b1;
          remain_next = run_len;
        end
      end
      // Any closing word ends the frame
      if (emit_empty) begin
        awaiting_next = 1'b0;
        pending_next  = '0;
        if (in_data.in_last) begin
          total_next  = '0;
          halted_next = 1'b0;
        end else begin
          halted_next = 1'b1;
        end
      end
    end else if (cmd.step) begin
      remain_next = remain - {5'd0, nv};
      total_next  = total_step;
      if (step_done) begin
        if (run_last) begin
          total_next  = '0;
          halted_next = 1'b0;
        end else begin
          halted_next = 1'b1;
        end
      end
    end
  end

  always_comb begin
    stat.slot_free = !out_valid || out_ready;
    stat.run_start = start_run;
    stat.run_final = step_final;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= LENGTH_RESET;
      awaiting        <= 1'b0;
      pending         <= '0;
      total           <= '0;
      halted          <= 1'b0;
      remain          <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        expected_length <= cfg_wr_data;
      end
      awaiting <= awaiting_next;
      pending  <= pending_next;
      total    <= total_next;
      halted   <= halted_next;
      remain   <= remain_next;
      if (emit_empty || cmd.step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Run byte and output word
  always_ff @(posedge clk) begin
    if (cmd.load && start_run) begin
      run_byte <= in_data.in_byte;
      run_last <= in_data.in_last;
    end
    if (emit_empty) begin
      out_data.byte_first     <= '0;
      out_data.byte_second    <= '0;
      out_data.bytes_valid    <= 2'd0;
      out_data.run_end        <= 1'b1;
      out_data.frame_done     <= 1'b1;
      out_data.status         <= empty_status;
      out_data.produced_count <= total;
    end else if (cmd.step) begin
      out_data.byte_first     <= run_byte;
      out_data.byte_second    <= (nv == 2'd2) ? run_byte : 8'd0;
      out_data.bytes_valid    <= nv;
      out_data.run_end        <= step_final;
      out_data.frame_done     <= step_done;
      out_data.status         <= STATUS_OK;
      out_data.produced_count <= total_step;
    end
  end

endmodule

// ===== hw/rtl/rle_escape_byte_decoder.sv =====
// Run-length byte decoder with escape byte.
// Input channel (in_valid/in_ready/in_data) takes one encoded byte per word,
// with in_last marking the final byte of a frame. Output channel
// (out_valid/out_ready/out_data) returns decoded bytes packed up to two per
// word, with run_end, frame_done, status and the running byte count.
// cfg_wr_en/cfg_wr_data set the expected frame length (reset value 8192);
// write it only while the decoder is idle.
// An empty closing word is ready in the cycle after the byte that causes
// it; for a literal or run, the controller first steps into its run state,
// and the first decoded word is then registered once the output is free.
// Marker, escape and dropped bytes are taken back to back; a literal or the
// value byte of a run holds in_ready low in the run state while the single
// output register emits one word per cycle, when the receiver is ready,
// until the run is done.
// A stalled receiver holds the output word; no new byte is taken and no run
// step advances until it is drained. Output words are registered, so a new
// byte is taken in the same cycle the previous word is drained.
// Synchronous reset clears the frame state and the output valid, and sets
// the expected length back to 8192.
module rle_escape_byte_decoder
  import rled_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data
);

  rled_cmd_t  cmd;
  rled_stat_t stat;

  rled_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rled_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ===== tb/tb_rle_escape_byte_decoder.sv =====
module tb_rle_escape_byte_decoder;
  import rled_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;

  rle_escape_byte_decoder uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // Decoder state as the testbench sees it
  int        frame_len;       // expected frame length register
  bit        value_pending;   // marker or escape waiting for its value byte
  int        repeat_count;    // run length of the pending value
  int        frame_total;     // bytes decoded so far in this frame
  bit        frame_halted;    // frame closed, bytes dropped until in_last
  out_word_t decoded_words[$];

  int        mismatch_count = 0;
  int        words_seen = 0;
  int        bytes_sent = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  out_word_t want_word;

  // Directed stimulus; typed rows carry the one output word they must cause
  typedef struct packed {
    logic        set_len;
    logic [15:0] len;
    logic [7:0]  code;
    logic        last;
    logic        typed;
    out_word_t   want;
  } dir_row_t;

  localparam out_word_t NO_WORD = '0;
  localparam int NUM_ROWS = 28;

  dir_row_t directed_rows [0:NUM_ROWS-1] = '{
    // literals at both ends of the range, then an escaped marker byte
    '{1'b0, 16'd0, 8'h00, 1'b0, 1'b1, '{8'h00, 8'h00, 2'd1, 1'b1, 1'b0, STATUS_OK, 16'd1}},
    '{1'b0, 16'd0, 8'h7F, 1'b0, 1'b1, '{8'h7F, 8'h00, 2'd1, 1'b1, 1'b0, STATUS_OK, 16'd2}},
    '{1'b0, 16'd0, 8'h55, 1'b0, 1'b0, NO_WORD},
    '{1'b0, 16'd0, 8'h80, 1'b0, 1'b1, '{8'h80, 8'h00, 2'd1, 1'b1, 1'b0, STATUS_OK, 16'd3}},
    // odd run, then zero-count runs, the last one closing the frame empty
    '{1'b0, 16'd0, 8'h83, 1'b0, 1'b0, NO_WORD},
    '{1'b0, 16'd0, 8'hA5, 1'b0, 1'b0, NO_WORD},
    '{1'b0, 16'd0, 8'h80, 1'b0, 1'b0, NO_WORD},
    '{1'b0, 16'd0, 8'h12, 1'b0, 1'b0, NO_WORD},
    '{1'b0, 16'd0, 8'h80, 1'b0, 1'b0, NO_WORD},
    '{1'b0, 16'd0, 8'h34, 1'b1, 1'b1, '{8'h00, 8'h00, 2'd0, 1'b1, 1'b1, STATUS_OK, 16'd6}},
    // longest run, then dangling escape and dangling marker
    '{1'b0, 16'd0, 8'hFF, 1'b0, 1'b0, NO_WORD},
    '{1'b0, 16'd0, 8'hFF, 1'b0, 1'b0, NO_WORD},
    '{1'b0, 16'd0, 8'h55, 1'b1, 1'b1,
      '{8'h00, 8'h00, 2'd0, 1'b1, 1'b1, STATUS_TRUNC, 16'd127}},
    '{1'b0, 16'd0, 8'h81, 1'b1, 1'b1, '{8'h00, 8'h00, 2'd0, 1'b1, 1'b1, STATUS_TRUNC, 16'd0}},
    '{1'b0, 16'd0, 8'h41, 1'b1, 1'b1, '{8'h41, 8'h00, 2'd1, 1'b1, 1'b1, STATUS_OK, 16'd1}},
    // short frame: overrun at the marker, bytes dropped until in_last
    '{1'b1, 16'd4, 8'h85, 1'b0, 1'b1,
      '{8'h00, 8'h00, 2'd0, 1'b1, 1'b1, STATUS_OVERRUN, 16'd0}},
    '{1'b0, 16'd0, 8'h01, 1'b0, 1'b0, NO_WORD},
    '{1'b0, 16'd0, 8'h02, 1'b1, 1'b0, NO_WORD},
    // length reached exactly, later bytes dropped
    '{1'b0, 16'd0, 8'h03, 1'b0, 1'b1, '{8'h03, 8'h00, 2'd1, 1'b1, 1'b0, STATUS_OK, 16'd1}},
    '{1'b0, 16'd0, 8'h82, 1'b0, 1'b0, NO_WORD},
    '{1'b0, 16'd0, 8'h66, 1'b0, 1'b1, '{8'h66, 8'h66, 2'd2, 1'b1, 1'b0, STATUS_OK, 16'd3}},
    '{1'b0, 16'd0, 8'h07, 1'b0, 1'b1, '{8'h07, 8'h00, 2'd1, 1'b1, 1'b1, STATUS_OK, 16'd4}},
    '{1'b0, 16'd0, 8'h08, 1'b0, 1'b0, NO_WORD},
    '{1'b0, 16'd0, 8'h09, 1'b1, 1'b0, NO_WORD},
    // zero length: length already met on the first byte
    '{1'b1, 16'd0, 8'h0A, 1'b1, 1'b1, '{8'h00, 8'h00, 2'd0, 1'b1, 1'b1, STATUS_OK, 16'd0}},
    // length lowered between marker and value: overrun at the value byte
    '{1'b1, 16'd4, 8'h84, 1'b0, 1'b0, NO_WORD},
    '{1'b1, 16'd2, 8'h5A, 1'b0, 1'b1,
      '{8'h00, 8'h00, 2'd0, 1'b1, 1'b1, STATUS_OVERRUN, 16'd0}},
    '{1'b0, 16'd0, 8'h00, 1'b1, 1'b0, NO_WORD}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #2000000;
    $display("tb_rle_escape_byte_decoder: done, errors");
    $finish;
  end

  function automatic void reset_frame();
    value_pending = 1'b0;
    repeat_count  = 0;
    frame_total   = 0;
    frame_halted  = 1'b0;
  endfunction

  function automatic void end_frame(bit last);
    if (last) begin
      reset_frame();
    end else begin
      frame_halted  = 1'b1;
      value_pending = 1'b0;
      repeat_count  = 0;
    end
  endfunction

  function automatic void emit_word(logic [7:0] b0, logic [7:0] b1, logic [1:0] nv,
                                    bit re, bit fd, logic [1:0] st);
    out_word_t w;
    w.byte_first     = b0;
    w.byte_second    = b1;
    w.bytes_valid    = nv;
    w.run_end        = re;
    w.frame_done     = fd;
    w.status         = st;
    w.produced_count = frame_total[15:0];
    decoded_words.push_back(w);
  endfunction

  // Empty word that closes the frame with the given status
  function automatic void close_empty(bit last, logic [1:0] st);
    emit_word(8'h00, 8'h00, 2'd0, 1'b1, 1'b1, st);
    end_frame(last);
  endfunction

  // Decode one encoded byte into the output words it causes
  function automatic void decode_byte(logic [7:0] b, bit last);
    int run;
    int nv;
    bit fin;
    bit done;
    if (frame_halted) begin
      if (last) reset_frame();
      return;
    end
    if (frame_total >= frame_len) begin
      close_empty(last, STATUS_OK);
      return;
    end
    if (!value_pending) begin
      if (b == ESCAPE_BYTE || b[MARK_BIT]) begin
        repeat_count = (b == ESCAPE_BYTE) ? 1 : int'(b[6:0]);
        if (frame_total + repeat_count > frame_len) begin
          close_empty(last, STATUS_OVERRUN);
          return;
        end
        value_pending = 1'b1;
        if (last) close_empty(last, STATUS_TRUNC);
        return;
      end
      run = 1;
    end else begin
      run = repeat_count;
      value_pending = 1'b0;
      repeat_count  = 0;
      if (frame_total + run > frame_len) begin
        close_empty(last, STATUS_OVERRUN);
        return;
      end
    end
    if (run == 0) begin
      if (last) close_empty(last, STATUS_OK);
      return;
    end
    // up to two bytes per word, run_end on the last word of the run
    while (run > 0) begin
      nv = (run >= 2) ? 2 : 1;
      run -= nv;
      frame_total = (frame_total + nv) & 16'hFFFF;
      fin = (run == 0);
      done = fin && (last || frame_total == frame_len);
      emit_word(b, (nv == 2) ? b : 8'h00, nv[1:0], fin, done, STATUS_OK);
      if (done) end_frame(last);
    end
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    $display("ERROR out word %0d: %s", words_seen, msg);
  endtask

  // Output check against the oldest expected word
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (decoded_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word %h", out_data));
      end else begin
        want_word = decoded_words.pop_front();
        if (out_data.byte_first != want_word.byte_first)
          flag_mismatch($sformatf("byte_first %h, want %h",
                                  out_data.byte_first, want_word.byte_first));
        if (out_data.byte_second != want_word.byte_second)
          flag_mismatch($sformatf("byte_second %h, want %h",
                                  out_data.byte_second, want_word.byte_second));
        if (out_data.bytes_valid != want_word.bytes_valid)
          flag_mismatch($sformatf("bytes_valid %0d, want %0d",
                                  out_data.bytes_valid, want_word.bytes_valid));
        if (out_data.run_end != want_word.run_end)
          flag_mismatch($sformatf("run_end %0d, want %0d",
                                  out_data.run_end, want_word.run_end));
        if (out_data.frame_done != want_word.frame_done)
          flag_mismatch($sformatf("frame_done %0d, want %0d",
                                  out_data.frame_done, want_word.frame_done));
        if (out_data.status != want_word.status)
          flag_mismatch($sformatf("status %0d, want %0d",
                                  out_data.status, want_word.status));
        if (out_data.produced_count != want_word.produced_count)
          flag_mismatch($sformatf("produced_count %0d, want %0d",
                                  out_data.produced_count, want_word.produced_count));
      end
      words_seen++;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Present one encoded byte and hold it until taken; entered at a falling edge
  task automatic send_byte(logic [7:0] b, bit last, bit typed, out_word_t want);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, in_last: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b, last);
    if (typed) decoded_words[decoded_words.size() - 1] = want;
    bytes_sent++;
    @(negedge clk);
  endtask

  // Stop sending, let every expected word arrive, then allow the last byte to settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (decoded_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_length(logic [15:0] len);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    frame_len = len;
  endtask

  // Mostly well-formed frame with random content; one part in ten is a raw byte
  task automatic send_random_frame();
    int parts;
    int p;
    int kind;
    bit fin;
    logic [7:0] v;
    parts = $urandom_range(1, 6);
    for (p = 0; p < parts; p++) begin
      fin  = (p == parts - 1);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_byte(8'($urandom_range(0, 255)), fin || ($urandom_range(0, 7) == 0),
                  1'b0, NO_WORD);
      end else if (kind < 5) begin
        v = 8'($urandom_range(0, 127));
        if (v == ESCAPE_BYTE) v = 8'h54;
        send_byte(v, fin, 1'b0, NO_WORD);
      end else begin
        // marker or escape followed by its value; runs are mostly short
        if (kind == 9)
          v = ESCAPE_BYTE;
        else if ($urandom_range(0, 7) == 0)
          v = {1'b1, 7'($urandom_range(0, 127))};
        else
          v = {1'b1, 7'($urandom_range(0, 8))};
        send_byte(v, 1'b0, 1'b0, NO_WORD);
        send_byte(8'($urandom_range(0, 255)), fin, 1'b0, NO_WORD);
      end
    end
  endtask

  initial begin
    int i;
    int blk;
    int start;
    logic [15:0] lens [0:7];
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    frame_len   = LENGTH_RESET;
    reset_frame();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, no idling
    for (i = 0; i < NUM_ROWS; i++) begin
      if (directed_rows[i].set_len) write_length(directed_rows[i].len);
      send_byte(directed_rows[i].code, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].want);
    end

    // Random part: two length settings per idling phase
    lens[0] = 16'hFFFF;
    lens[1] = 16'($urandom_range(3, 24));
    lens[2] = 16'd0;
    lens[3] = 16'($urandom_range(3, 24));
    lens[4] = 16'($urandom_range(25, 65534));
    lens[5] = 16'($urandom_range(3, 24));
    lens[6] = 16'd1;
    lens[7] = 16'($urandom_range(3, 24));
    for (blk = 0; blk < 8; blk++) begin
      case (blk / 2)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 75;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 75;
        end
        default: begin
          send_idle_pct = 36;
          stall_pct = 36;
        end
      endcase
      write_length(lens[blk]);
      start = bytes_sent;
      while (bytes_sent - start < 8) send_random_frame();
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb_rle_escape_byte_decoder: done, clean");
    end else begin
      $display("tb_rle_escape_byte_decoder: done, errors");
    end
    $finish;
  end

endmodule
